/* hw/rtl/akvs_pkg.sv */
// ----------------------------------------------------------------------------
// akvs_pkg
// Shared constants for the append-only key/value store.
// ----------------------------------------------------------------------------
package akvs_pkg;

    localparam int          ENTRIES_DEFAULT      = 16;
    localparam logic [7:0]  RESERVED_KEY_DEFAULT = 8'hFF;

    localparam int KEY_W = 8;
    localparam int VAL_W = 8;

    // opcodes carried in s_tuser
    localparam logic OP_LOOKUP = 1'b0;
    localparam logic OP_SAVE   = 1'b1;

    // sequencer states
    localparam int ST_W = 3;
    localparam logic [ST_W-1:0] ST_IDLE = 3'd0;
    localparam logic [ST_W-1:0] ST_SCAN = 3'd1;
    localparam logic [ST_W-1:0] ST_VAL  = 3'd2;
    localparam logic [ST_W-1:0] ST_RESP = 3'd3;

endpackage

/* hw/rtl/append_key_value_store_core.sv */
// ----------------------------------------------------------------------------
// append_key_value_store_core
// Keyed byte store held as an ordered list with a fill count.
// ----------------------------------------------------------------------------
// Usage:
//   Requests enter on the s_ stream: s_tuser is the opcode (lookup or save),
//   s_tdata carries the key and the value to save. Each request gives exactly
//   one reply on the m_ stream: m_tuser is the ok flag, m_tdata the value read
//   on a successful lookup (zero otherwise).
//   Timing: one request at a time. The key memory is scanned one entry per
//   cycle through its single registered read port, so the time from acceptance
//   to reply grows with the number of entries scanned; a reserved key is answered
//   without a scan. The sequencer returns to idle after each reply before the
//   next request is taken.
//   s_tready is high only while the sequencer is idle; a reply waits in the
//   output register for as long as m_tready is low.
//   Reset (aresetn low, synchronous) empties the table by clearing the fill
//   count; the memories are not cleared, no clearing pass is needed.
// ----------------------------------------------------------------------------
module append_key_value_store_core
    import akvs_pkg::*;
#(
    parameter int         ENTRIES      = ENTRIES_DEFAULT,
    parameter logic [7:0] RESERVED_KEY = RESERVED_KEY_DEFAULT
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [15:0] s_tdata,   // [7:0] key, [15:8] new_value
    input  logic [0:0]  s_tuser,   // [0] opcode
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [7:0]  m_tdata,   // [7:0] read_value
    output logic [0:0]  m_tuser    // [0] ok
);

    localparam int IW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int CW = $clog2(ENTRIES + 1);
    localparam logic [CW-1:0] ENTRIES_C = CW'(ENTRIES);

    logic [KEY_W-1:0] key_mem [ENTRIES];
    logic [VAL_W-1:0] val_mem [ENTRIES];

    logic [ST_W-1:0]  state_reg, state_next;
    logic [CW-1:0]    idx_reg, idx_next;
    logic [CW-1:0]    used_reg, used_next;
    logic             op_reg, op_next;
    logic [KEY_W-1:0] key_reg, key_next;
    logic [VAL_W-1:0] nval_reg, nval_next;
    logic             ok_reg, ok_next;
    logic [VAL_W-1:0] rval_reg, rval_next;

    logic [KEY_W-1:0] key_rd_reg;
    logic [VAL_W-1:0] val_rd_reg;
    logic [CW-1:0]    rd_idx;
    logic [IW-1:0]    key_rd_addr;
    logic             wr_key, wr_val;
    logic [IW-1:0]    wr_addr;
    logic             s_acc;

    assign s_tready = (state_reg == ST_IDLE);
    assign s_acc    = s_tvalid && s_tready;
    assign m_tvalid = (state_reg == ST_RESP);
    assign m_tdata  = rval_reg;
    assign m_tuser  = ok_reg;

    // next entry to fetch; out-of-range fetches are steered to entry 0 and unused
    always_comb begin
        rd_idx = (state_reg == ST_IDLE) ? '0 : idx_reg + 1'b1;
        if (rd_idx >= ENTRIES_C) begin
            key_rd_addr = '0;
        end else begin
            key_rd_addr = rd_idx[IW-1:0];
        end
    end

    always_comb begin
        state_next = state_reg;
        idx_next   = idx_reg;
        used_next  = used_reg;
        op_next    = op_reg;
        key_next   = key_reg;
        nval_next  = nval_reg;
        ok_next    = ok_reg;
        rval_next  = rval_reg;
        wr_key     = 1'b0;
        wr_val     = 1'b0;
        wr_addr    = idx_reg[IW-1:0];

        case (state_reg)
            ST_IDLE: begin
                if (s_acc) begin
                    op_next   = s_tuser[0];
                    key_next  = s_tdata[7:0];
                    nval_next = s_tdata[15:8];
                    idx_next  = '0;
                    ok_next   = 1'b0;
                    rval_next = '0;
                    if (s_tdata[7:0] == RESERVED_KEY) begin
                        state_next = ST_RESP;
                    end else begin
                        state_next = ST_SCAN;
                    end
                end
            end
            ST_SCAN: begin
                // key_rd_reg holds the key of entry idx_reg
                if (idx_reg >= used_reg) begin
                    // no match among used entries
                    if (op_reg == OP_SAVE && used_reg < ENTRIES_C) begin
                        wr_key    = 1'b1;
                        wr_val    = 1'b1;
                        wr_addr   = used_reg[IW-1:0];
                        used_next = used_reg + 1'b1;
                        ok_next   = 1'b1;
                    end
                    state_next = ST_RESP;
                end else if (key_rd_reg == key_reg) begin
                    if (op_reg == OP_SAVE) begin
                        wr_val     = 1'b1;
                        ok_next    = 1'b1;
                        state_next = ST_RESP;
                    end else begin
                        state_next = ST_VAL;
                    end
                end else begin
                    idx_next = idx_reg + 1'b1;
                end
            end
            ST_VAL: begin
                ok_next    = 1'b1;
                rval_next  = val_rd_reg;
                state_next = ST_RESP;
            end
            ST_RESP: begin
                if (m_tready) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            used_reg  <= '0;
            idx_reg   <= '0;
        end else begin
            state_reg <= state_next;
            used_reg  <= used_next;
            idx_reg   <= idx_next;
        end
    end

    always_ff @(posedge aclk) begin
        op_reg   <= op_next;
        key_reg  <= key_next;
        nval_reg <= nval_next;
        ok_reg   <= ok_next;
        rval_reg <= rval_next;
    end

    // key memory: one write, one registered read per cycle
    always_ff @(posedge aclk) begin
        if (wr_key) begin
            key_mem[wr_addr] <= key_reg;
        end
        key_rd_reg <= key_mem[key_rd_addr];
    end

    // value memory: read at the current scan entry, latched on the matching cycle
    always_ff @(posedge aclk) begin
        if (wr_val) begin
            val_mem[wr_addr] <= nval_reg;
        end
        if (idx_reg < ENTRIES_C) begin
            val_rd_reg <= val_mem[idx_reg[IW-1:0]];
        end
    end

endmodule

/* sim/akvs_reply_checker.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// akvs_reply_checker
// Keeps a shadow copy of the key/value table from the accepted requests and
// checks every reply, field by field, against the oldest one still owed.
// ----------------------------------------------------------------------------
module akvs_reply_checker
    import akvs_pkg::*;
#(
    parameter int         ENTRIES      = ENTRIES_DEFAULT,
    parameter logic [7:0] RESERVED_KEY = RESERVED_KEY_DEFAULT
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic [15:0] s_tdata,   // [7:0] key, [15:8] new_value
    input  logic [0:0]  s_tuser,   // [0] opcode
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [7:0]  m_tdata,   // [7:0] read_value
    input  logic [0:0]  m_tuser,   // [0] ok
    output int          mismatches,
    output int          replies_owed
);

    typedef struct packed {
        logic       ok;
        logic [7:0] read_value;
    } reply_t;

    logic [7:0] shadow_keys [ENTRIES];
    logic [7:0] shadow_vals [ENTRIES];
    int         shadow_fill;
    int         fail_tally;
    reply_t     replies_due [$];

    initial begin
        fail_tally   = 0;
        shadow_fill  = 0;
    end

    // applies one request to the shadow table and returns the reply it earns
    function automatic reply_t serve_request(input logic op, input logic [7:0] key,
                                             input logic [7:0] val);
        reply_t r;
        int     slot;
        r    = '0;
        slot = ENTRIES;
        if (key != RESERVED_KEY) begin
            // first match wins
            for (int i = 0; i < shadow_fill; i++) begin
                if (slot == ENTRIES && shadow_keys[i] == key)
                    slot = i;
            end
            if (op == OP_LOOKUP) begin
                if (slot < ENTRIES) begin
                    r.ok         = 1'b1;
                    r.read_value = shadow_vals[slot];
                end
            end else if (slot < ENTRIES) begin
                shadow_vals[slot] = val;
                r.ok              = 1'b1;
            end else if (shadow_fill < ENTRIES) begin
                shadow_keys[shadow_fill] = key;
                shadow_vals[shadow_fill] = val;
                shadow_fill++;
                r.ok = 1'b1;
            end
        end
        return r;
    endfunction

    always @(posedge aclk) begin : check_replies
        reply_t want;
        if (!aresetn) begin
            shadow_fill = 0;
            replies_due.delete();
        end else begin
            // request side first: a reply can never belong to an item taken at the same edge,
            // but the queue must hold every item taken up to now
            if (s_tvalid && s_tready)
                replies_due.push_back(serve_request(s_tuser[0], s_tdata[7:0], s_tdata[15:8]));
            if (m_tvalid && m_tready) begin
                if (replies_due.size() == 0) begin
                    $error("reply with no request outstanding: ok %0d, read_value 0x%02h",
                           m_tuser[0], m_tdata);
                    fail_tally++;
                end else begin
                    want = replies_due.pop_front();
                    if (m_tuser[0] !== want.ok) begin
                        $error("ok: expected %0d, got %0d", want.ok, m_tuser[0]);
                        fail_tally++;
                    end
                    if (m_tdata !== want.read_value) begin
                        $error("read_value: expected 0x%02h, got 0x%02h",
                               want.read_value, m_tdata);
                        fail_tally++;
                    end
                end
            end
        end
        mismatches   <= fail_tally;
        replies_owed <= replies_due.size();
    end

endmodule

/* sim/testbench.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Drives lookups and saves into the key/value store: a directed pass over the
// empty, partly filled and full table, then random requests mostly on stored
// keys, with random gaps on both sides and one long reply stall.
// ----------------------------------------------------------------------------
module testbench;
    import akvs_pkg::*;

    localparam int RESET_CYCLES    = 11;
    localparam int RANDOM_REQUESTS = 375;
    localparam int HOLD_AT         = 150;     // reply count at which the long stall starts
    localparam int HOLD_CYCLES     = 400;
    localparam int DRAIN_CYCLES    = 25;      // margin after all replies are in
    localparam int CYCLE_LIMIT     = 200000;

    logic        aclk     = 1'b0;
    logic        aresetn  = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [15:0] s_tdata  = '0;        // [7:0] key, [15:8] new_value
    logic [0:0]  s_tuser  = OP_LOOKUP; // [0] opcode
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [7:0]  m_tdata;              // [7:0] read_value
    logic [0:0]  m_tuser;              // [0] ok

    int         mismatches;
    int         replies_owed;
    int         cycles        = 0;
    int         requests_sent = 0;
    logic [7:0] fill_keys [ENTRIES_DEFAULT];

    always #4 aclk = ~aclk;

    append_key_value_store_core u_top (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    akvs_reply_checker u_checker (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_tvalid     (s_tvalid),
        .s_tready     (s_tready),
        .s_tdata      (s_tdata),
        .s_tuser      (s_tuser),
        .m_tvalid     (m_tvalid),
        .m_tready     (m_tready),
        .m_tdata      (m_tdata),
        .m_tuser      (m_tuser),
        .mismatches   (mismatches),
        .replies_owed (replies_owed)
    );

    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles == CYCLE_LIMIT) begin
            $display("[append_key_value_store_core] ERROR");
            $finish;
        end
    end

    // every third run of 40 items goes without any idling
    function automatic int pick_gap(input int n);
        if ((n / 40) % 3 == 2)
            return 0;
        return $urandom_range(0, 17);
    endfunction

    task automatic send_request(input logic op, input logic [7:0] key, input logic [7:0] val);
        int gap;
        gap = pick_gap(requests_sent);
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= {val, key};
        do @(posedge aclk); while (!(s_tvalid && s_tready));
        requests_sent++;
    endtask

    initial begin : reply_sink
        int wait_cycles;
        int taken;
        taken = 0;
        while (!aresetn) @(posedge aclk);
        forever begin
            if (taken == HOLD_AT)
                wait_cycles = HOLD_CYCLES;
            else
                wait_cycles = pick_gap(taken);
            if (wait_cycles > 0) begin
                m_tready <= 1'b0;
                repeat (wait_cycles) @(posedge aclk);
            end
            m_tready <= 1'b1;
            do @(posedge aclk); while (!(m_tvalid && m_tready));
            taken++;
        end
    end

    initial begin : stimulus
        int         pick;
        logic [7:0] key;
        logic       op;
        repeat (RESET_CYCLES) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // empty table lookup, save on the reserved key
        send_request(OP_LOOKUP, 8'h00, 8'h00);
        send_request(OP_SAVE, RESERVED_KEY_DEFAULT, 8'h05);
        // extremes of key and value, lookup ignores new_value
        fill_keys[0] = 8'h00;
        fill_keys[1] = 8'hFE;
        send_request(OP_SAVE, fill_keys[0], 8'h00);
        send_request(OP_SAVE, fill_keys[1], 8'hFF);
        send_request(OP_LOOKUP, fill_keys[0], 8'hFF);
        send_request(OP_LOOKUP, fill_keys[1], 8'h5A);
        send_request(OP_SAVE, fill_keys[0], 8'hA5);
        send_request(OP_LOOKUP, 8'h01, 8'h00);
        send_request(OP_LOOKUP, RESERVED_KEY_DEFAULT, 8'h00);
        // fill up, then a new key on the full table and an update on it
        for (int i = 2; i < ENTRIES_DEFAULT; i++) begin
            fill_keys[i] = 8'((i - 1) * 16 + 1);
            send_request(OP_SAVE, fill_keys[i], 8'((i - 1) * 17));
        end
        send_request(OP_SAVE, 8'h99, 8'h42);
        send_request(OP_LOOKUP, fill_keys[ENTRIES_DEFAULT-1], 8'h00);
        send_request(OP_SAVE, fill_keys[1], 8'h3C);

        // random requests, mostly on stored keys
        for (int n = 0; n < RANDOM_REQUESTS; n++) begin
            pick = $urandom_range(0, 19);
            if (pick < 3)
                key = RESERVED_KEY_DEFAULT;
            else if (pick < 10)
                key = 8'($urandom_range(0, 255));
            else
                key = fill_keys[$urandom_range(0, ENTRIES_DEFAULT - 1)];
            op = ($urandom_range(0, 1) == 0) ? OP_LOOKUP : OP_SAVE;
            send_request(op, key, 8'($urandom_range(0, 255)));
        end
        s_tvalid <= 1'b0;

        // owed count is registered from the checker's queue
        @(posedge aclk);
        while (replies_owed != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (mismatches == 0 && replies_owed == 0)
            $display("[append_key_value_store_core] OK");
        else
            $display("[append_key_value_store_core] ERROR");
        $finish;
    end

endmodule

/* filelist.f */
hw/rtl/akvs_pkg.sv
hw/rtl/append_key_value_store_core.sv
sim/akvs_reply_checker.sv
sim/testbench.sv
